/* rtl/bdalu_pkg.sv */
// types, widths and constants shared by the byte alu with decimal mode
package bdalu_pkg;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [3:0] {
    FN_ADC  = 4'd0,
    FN_SBC  = 4'd1,
    FN_AND  = 4'd2,
    FN_OR   = 4'd3,
    FN_XOR  = 4'd4,
    FN_ASL  = 4'd5,
    FN_LSR  = 4'd6,
    FN_ROL  = 4'd7,
    FN_ROR  = 4'd8,
    FN_INC  = 4'd9,
    FN_DEC  = 4'd10,
    FN_CMP  = 4'd11,
    FN_BIT  = 4'd12,
    FN_PASS = 4'd13
  } alu_func_t;

  // decimal correction constants
  localparam logic [7:0] BCD_SBC_BIAS = 8'h66;
  localparam logic [7:0] BCD_LO_ADJ   = 8'h06;
  localparam logic [7:0] BCD_HI_ADJ   = 8'h60;
  localparam logic [3:0] BCD_MAX_DIG  = 4'h9;

  typedef struct packed {
    logic [7:0] result;
    logic       n;
    logic       z;
    logic       c;
    logic       v;
  } alu_res_t;

endpackage

/* rtl/byte_alu_with_decimal_mode_unit.sv */
// byte alu with decimal add/subtract correction, input and result registered
//
//  channel | dir | handshake               | payload
//  in_     | in  | in_tvalid / in_tready   | tdata: a, b, c, v   tuser: func, decimal_mode
//  out_    | out | out_tvalid / out_tready | tdata: result, n, z, c, v
//
// one item per cycle while out_ is not stalled; a transfer in reaches out_tvalid
// through the input register and then the result register around the alu
// rst_n is synchronous and clears both valid flags; payload registers are not reset
// a stall on out_ holds the result and lets one more item sit in the input register
// in_tready drops only when both registers are full and out_tready is low
module byte_alu_with_decimal_mode_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] operand_a, [15:8] operand_b, [16] carry_in, [17] overflow_in, zero pad
  input  logic [bdalu_pkg::IN_DATA_W-1:0]  in_tdata,
  // [3:0] func, [4] decimal_mode
  input  logic [bdalu_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] result_byte, [8] negative_out, [9] zero_out, [10] carry_out,
  // [11] overflow_out, zero pad
  output logic [bdalu_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bdalu_pkg::*;

  logic       s1_valid_r;
  logic [3:0] func_r;
  logic [7:0] a_r;
  logic [7:0] b_r;
  logic       c_r;
  logic       v_r;
  logic       dec_r;

  logic       out_valid_r;
  alu_res_t   res_r;
  alu_res_t   res_nxt;

  logic       out_free;
  logic       s1_move;
  logic       in_xfer;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_tuser[3:0];
      dec_r  <= in_tuser[4];
      a_r    <= in_tdata[7:0];
      b_r    <= in_tdata[15:8];
      c_r    <= in_tdata[16];
      v_r    <= in_tdata[17];
    end
  end

  // alu
  always_comb begin
    logic       is_sbc;
    logic [7:0] op;
    logic [8:0] bin_sum;
    logic [7:0] dsum;
    logic       dcarry;
    logic [8:0] diff;
    logic [7:0] r;

    is_sbc  = (func_r == FN_SBC);
    op      = is_sbc ? ~b_r : b_r;
    bin_sum = {1'b0, a_r} + {1'b0, op} + {8'd0, c_r};
    diff    = {1'b0, a_r} - {1'b0, b_r};

    // only the low byte of the decimal sum is ever seen
    dsum   = bin_sum[7:0] - (is_sbc ? BCD_SBC_BIAS : 8'h00);
    dcarry = 1'b0;
    if (dsum[3:0] > BCD_MAX_DIG) begin
      dsum = dsum + BCD_LO_ADJ;
    end
    if (dsum[7:4] > BCD_MAX_DIG) begin
      dsum   = dsum + BCD_HI_ADJ;
      dcarry = 1'b1;
    end

    r         = a_r;
    res_nxt.c = c_r;
    res_nxt.v = v_r;
    res_nxt.n = 1'b0;
    res_nxt.z = 1'b0;

    case (func_r)
      FN_ADC, FN_SBC: begin
        r         = dec_r ? dsum : bin_sum[7:0];
        res_nxt.c = dec_r ? dcarry : bin_sum[8];
        res_nxt.v = ((a_r[7] ^ r[7]) & (op[7] ^ r[7]));
      end
      FN_AND:  r = a_r & b_r;
      FN_OR:   r = a_r | b_r;
      FN_XOR:  r = a_r ^ b_r;
      FN_ASL: begin
        r         = {b_r[6:0], 1'b0};
        res_nxt.c = b_r[7];
      end
      FN_LSR: begin
        r         = {1'b0, b_r[7:1]};
        res_nxt.c = b_r[0];
      end
      FN_ROL: begin
        r         = {b_r[6:0], c_r};
        res_nxt.c = b_r[7];
      end
      FN_ROR: begin
        r         = {c_r, b_r[7:1]};
        res_nxt.c = b_r[0];
      end
      FN_INC:  r = b_r + 8'd1;
      FN_DEC:  r = b_r - 8'd1;
      FN_PASS: r = b_r;
      default: r = a_r;
    endcase

    res_nxt.result = r;
    if (func_r == FN_CMP) begin
      res_nxt.n = diff[7];
      res_nxt.z = (a_r == b_r);
      res_nxt.c = !diff[8];
    end else if (func_r == FN_BIT) begin
      res_nxt.n = b_r[7];
      res_nxt.z = ((a_r & b_r) == 8'h00);
      res_nxt.v = b_r[6];
    end else begin
      res_nxt.n = r[7];
      res_nxt.z = (r == 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.v, res_r.c, res_r.z, res_r.n, res_r.result};

  // an empty input register never blocks a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("in_tready low with empty input register");

  // an accepted item is held until it moves on
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted item lost");

  // a held item that cannot move stays
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("stalled item dropped");

  // an item leaving the input register shows up as a result
  a_move_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("moved item did not reach the result register");

  // compare and bit test return the register operand unchanged
  a_cmp_bit_keep_a: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (func_r == FN_CMP || func_r == FN_BIT))
      |=> res_r.result == $past(a_r))
    else $error("compare or bit test changed the result byte");

endmodule

/* dv/byte_alu_result_checker.sv */
// result checker for the byte alu: predicts each transfer in and compares the transfers out
module byte_alu_result_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [bdalu_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [bdalu_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [bdalu_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                               error_count,
  output int                               results_owed
);
  import bdalu_pkg::*;

  localparam logic [15:0] DEC_SUB_BIAS = 16'h0066;
  localparam logic [15:0] DEC_LO_FIX   = 16'h0006;
  localparam logic [15:0] DEC_HI_FIX   = 16'h0060;
  localparam logic [3:0]  DEC_TOP_DIG  = 4'h9;

  alu_res_t owed_q[$];

  initial begin
    error_count  = 0;
    results_owed = 0;
  end

  function automatic alu_res_t alu_predict(logic [3:0] fn, logic [7:0] a, logic [7:0] b,
                                           logic c, logic v, logic dec);
    logic [7:0]  op;
    logic [7:0]  r;
    logic [7:0]  diff;
    logic [15:0] sum;
    logic [8:0]  wide;
    logic        n;
    logic        z;
    logic        nz_from_r;
    alu_res_t    res;
    r         = a;
    n         = 1'b0;
    z         = 1'b0;
    nz_from_r = 1'b1;
    case (fn)
      FN_ADC, FN_SBC: begin
        op  = (fn == FN_SBC) ? ~b : b;
        sum = 16'(a) + 16'(op) + 16'(c);
        if (dec) begin
          if (fn == FN_SBC) sum = sum - DEC_SUB_BIAS;
          if (sum[3:0] > DEC_TOP_DIG) sum = sum + DEC_LO_FIX;
          // decimal carry comes only from the high nibble fix
          c = (sum[7:4] > DEC_TOP_DIG);
          if (c) sum = sum + DEC_HI_FIX;
        end else begin
          c = sum[8];
        end
        r    = sum[7:0];
        diff = (a ^ r) & (op ^ r);
        v    = diff[7];
      end
      FN_AND: r = a & b;
      FN_OR:  r = a | b;
      FN_XOR: r = a ^ b;
      FN_ASL: begin
        c = b[7];
        r = {b[6:0], 1'b0};
      end
      FN_LSR: begin
        c = b[0];
        r = {1'b0, b[7:1]};
      end
      FN_ROL: begin
        wide = {b, c};
        c    = wide[8];
        r    = wide[7:0];
      end
      FN_ROR: begin
        wide = {c, b};
        c    = wide[0];
        r    = wide[8:1];
      end
      FN_INC: r = b + 8'd1;
      FN_DEC: r = b - 8'd1;
      FN_CMP: begin
        diff      = a - b;
        n         = diff[7];
        z         = (a == b);
        c         = (a >= b);
        nz_from_r = 1'b0;
      end
      FN_BIT: begin
        z         = ((a & b) == 8'd0);
        n         = b[7];
        v         = b[6];
        nz_from_r = 1'b0;
      end
      FN_PASS: r = b;
      default: r = a;
    endcase
    if (nz_from_r) begin
      n = r[7];
      z = (r == 8'd0);
    end
    res.result = r;
    res.n      = n;
    res.z      = z;
    res.c      = c;
    res.v      = v;
    return res;
  endfunction

  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("result error: transfer out with nothing owed, data %h", out_tdata);
        end else begin
          want = owed_q.pop_front();
          if (out_tdata[7:0] !== want.result || out_tdata[8] !== want.n ||
              out_tdata[9] !== want.z || out_tdata[10] !== want.c ||
              out_tdata[11] !== want.v) begin
            error_count = error_count + 1;
            if (error_count <= 10)
              $display({"result error: expected r=%h n=%b z=%b c=%b v=%b, ",
                        "got r=%h n=%b z=%b c=%b v=%b"},
                       want.result, want.n, want.z, want.c, want.v, out_tdata[7:0],
                       out_tdata[8], out_tdata[9], out_tdata[10], out_tdata[11]);
          end
        end
      end
      if (in_tvalid && in_tready)
        owed_q.push_back(alu_predict(in_tuser[3:0], in_tdata[7:0], in_tdata[15:8],
                                     in_tdata[16], in_tdata[17], in_tuser[4]));
    end
    results_owed <= owed_q.size();
  end

endmodule

/* dv/byte_alu_with_decimal_mode_unit_test.sv */
// stimulus and verdict for the byte alu with decimal mode
module byte_alu_with_decimal_mode_unit_test;
  import bdalu_pkg::*;

  // codes outside the operation list, treated as a no-op
  localparam logic [3:0] FN_SPARE_LO = 4'd14;
  localparam logic [3:0] FN_SPARE_HI = 4'd15;
  localparam int RANDOM_OPS = 950;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [7:0] operand_a, [15:8] operand_b, [16] carry_in, [17] overflow_in, zero pad
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // [3:0] func, [4] decimal_mode
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [7:0] result_byte, [8] negative_out, [9] zero_out, [10] carry_out, [11] overflow_out
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    error_count;
  int                    results_owed;
  bit                    steady     = 1'b0;

  always #2 clk = ~clk;

  byte_alu_with_decimal_mode_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  byte_alu_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_count (error_count),
    .results_owed(results_owed)
  );

  always @(posedge clk) begin
    if (rst_n) out_tready <= steady || ($urandom_range(99) >= 34);
  end

  task automatic send_op(logic [3:0] fn, logic [7:0] a, logic [7:0] b,
                         logic c, logic v, logic dec);
    in_tdata  <= {6'd0, v, c, b, a};
    in_tuser  <= {dec, fn};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // random idle cycles before the next transfer
    while (!steady && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_byte(bit bcd);
    logic [7:0] edges [5];
    edges = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01};
    if (bcd) return {4'($urandom_range(9)), 4'($urandom_range(9))};
    if ($urandom_range(99) < 10) return edges[3'($urandom_range(4))];
    return 8'($urandom);
  endfunction

  initial begin
    logic [3:0] fn;
    bit         dec;
    bit         bcd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // binary add and subtract at the extremes, signed overflow both ways
    send_op(FN_ADC, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
    send_op(FN_ADC, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0);
    send_op(FN_ADC, 8'h7f, 8'h01, 1'b0, 1'b0, 1'b0);
    send_op(FN_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);
    send_op(FN_SBC, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    // decimal: wrap at 99, borrow below 00, non-bcd digits
    send_op(FN_ADC, 8'h99, 8'h01, 1'b0, 1'b0, 1'b1);
    send_op(FN_ADC, 8'h0f, 8'h0f, 1'b1, 1'b0, 1'b1);
    send_op(FN_ADC, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1);
    send_op(FN_SBC, 8'h00, 8'h01, 1'b1, 1'b0, 1'b1);
    send_op(FN_SBC, 8'h50, 8'h25, 1'b0, 1'b1, 1'b1);
    send_op(FN_SBC, 8'hff, 8'h00, 1'b1, 1'b0, 1'b1);
    send_op(FN_AND, 8'hf0, 8'h0f, 1'b1, 1'b1, 1'b0);
    send_op(FN_OR,  8'h80, 8'h01, 1'b0, 1'b0, 1'b1);
    send_op(FN_XOR, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0);
    send_op(FN_ASL, 8'h00, 8'h80, 1'b0, 1'b1, 1'b0);
    send_op(FN_LSR, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0);
    send_op(FN_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0);
    send_op(FN_ROR, 8'h00, 8'h01, 1'b1, 1'b1, 1'b1);
    send_op(FN_INC, 8'h00, 8'hff, 1'b0, 1'b0, 1'b0);
    send_op(FN_DEC, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
    send_op(FN_CMP, 8'h40, 8'h40, 1'b0, 1'b1, 1'b0);
    send_op(FN_CMP, 8'h00, 8'hff, 1'b1, 1'b0, 1'b0);
    send_op(FN_BIT, 8'h0f, 8'hc0, 1'b1, 1'b0, 1'b0);
    send_op(FN_PASS, 8'hff, 8'h00, 1'b0, 1'b1, 1'b0);
    send_op(FN_SPARE_LO, 8'h00, 8'h55, 1'b1, 1'b0, 1'b1);
    send_op(FN_SPARE_HI, 8'h80, 8'haa, 1'b0, 1'b1, 1'b0);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      steady = (i >= 400 && i < 550);
      if ($urandom_range(99) < 3)
        fn = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
      else if ($urandom_range(99) < 30)
        fn = $urandom_range(1) ? FN_SBC : FN_ADC;
      else
        fn = 4'($urandom_range(FN_PASS));
      dec = 1'($urandom_range(1));
      // decimal add and subtract mostly on valid bcd digits
      bcd = dec && (fn == FN_ADC || fn == FN_SBC) && ($urandom_range(99) < 60);
      send_op(fn, pick_byte(bcd), pick_byte(bcd), 1'($urandom), 1'($urandom), dec);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
